// ===== hw/rtl/hre_pkg.sv =====
// Shared types and constants for the heartbeat role election block.
package hre_pkg;

  localparam int unsigned CntW       = 16;
  localparam int unsigned PaddrW     = 5;
  localparam int unsigned PdataW     = 32;
  localparam int unsigned ByteCountW = 11;

  localparam logic [31:0]       TagValueRst    = 32'hFFEE_00EF;
  localparam logic [CntW-1:0]   StaleLimitRst  = 16'd500;
  localparam logic [CntW-1:0]   RxWindowRst    = 16'd500;
  localparam logic [CntW-1:0]   BeatPeriodRst  = 16'd250;
  localparam logic [ByteCountW-1:0] MinTaggedBytes = 11'd8;

  typedef enum logic [1:0] {
    RoleSecondary = 2'd0,
    RoleRaise     = 2'd1,
    RolePrimary   = 2'd2
  } role_e;

  typedef enum logic [0:0] {
    KindTick   = 1'b0,
    KindPacket = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    RegTagValue   = 3'd0,
    RegOwnNodeId  = 3'd1,
    RegOwnInst    = 3'd2,
    RegStaleLimit = 3'd3,
    RegRxWindow   = 3'd4,
    RegBeatPeriod = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [0:0]            kind;
    logic [ByteCountW-1:0] byte_count;
    logic [31:0]           packet_tag;
    logic signed [15:0]    sender_id;
    logic signed [15:0]    sender_instance;
  } in_word_t;

  typedef struct packed {
    logic [1:0] role;
    logic       send_beat;
    logic       role_changed;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        tag_value;
    logic signed [15:0] own_node_id;
    logic signed [15:0] own_instance;
    logic [CntW-1:0]    stale_limit_ms;
    logic [CntW-1:0]    receive_window_ms;
    logic [CntW-1:0]    beat_period_ms;
  } cfg_t;

  // Count up by one, hold at full scale.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
  endfunction

  // Secondary goes to raise hand; anything else drops to secondary.
  function automatic role_e toggle_role(input role_e r);
    return (r == RoleSecondary) ? RoleRaise : RoleSecondary;
  endfunction

endpackage

// ===== hw/rtl/hre_cfg.sv =====
// APB-style register file holding the election settings.
module hre_cfg import hre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag_value         <= TagValueRst;
      cfg_q.own_node_id       <= '0;
      cfg_q.own_instance      <= '0;
      cfg_q.stale_limit_ms    <= StaleLimitRst;
      cfg_q.receive_window_ms <= RxWindowRst;
      cfg_q.beat_period_ms    <= BeatPeriodRst;
    end else if (wr_en) begin
      unique case (idx)
        RegTagValue:   cfg_q.tag_value         <= pwdata;
        RegOwnNodeId:  cfg_q.own_node_id       <= pwdata[15:0];
        RegOwnInst:    cfg_q.own_instance      <= pwdata[15:0];
        RegStaleLimit: cfg_q.stale_limit_ms    <= pwdata[CntW-1:0];
        RegRxWindow:   cfg_q.receive_window_ms <= pwdata[CntW-1:0];
        RegBeatPeriod: cfg_q.beat_period_ms    <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegTagValue:   prdata = cfg_q.tag_value;
      RegOwnNodeId:  prdata = {16'd0, cfg_q.own_node_id};
      RegOwnInst:    prdata = {16'd0, cfg_q.own_instance};
      RegStaleLimit: prdata = {{(PdataW-CntW){1'b0}}, cfg_q.stale_limit_ms};
      RegRxWindow:   prdata = {{(PdataW-CntW){1'b0}}, cfg_q.receive_window_ms};
      RegBeatPeriod: prdata = {{(PdataW-CntW){1'b0}}, cfg_q.beat_period_ms};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/hre_core.sv =====
// Role and counter state with the combinational update for one word.
module hre_core import hre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_word_t  item_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  role_e           role_q, role_d;
  logic [CntW-1:0] since_q, since_d;
  logic [CntW-1:0] silence_q, silence_d;
  logic [CntW-1:0] beat_q, beat_d;
  logic            send_beat;
  logic            tag_hit, from_self;
  logic [CntW-1:0] win, per;

  assign win = (cfg_i.receive_window_ms == '0) ? {{(CntW-1){1'b0}}, 1'b1}
                                               : cfg_i.receive_window_ms;
  assign per = (cfg_i.beat_period_ms == '0) ? {{(CntW-1){1'b0}}, 1'b1}
                                            : cfg_i.beat_period_ms;
  assign tag_hit   = (item_i.byte_count >= MinTaggedBytes) &&
                     (item_i.packet_tag == cfg_i.tag_value);
  assign from_self = (item_i.sender_id == cfg_i.own_node_id) &&
                     (item_i.sender_instance == cfg_i.own_instance);

  always_comb begin
    role_d    = role_q;
    since_d   = since_q;
    silence_d = silence_q;
    beat_d    = beat_q;
    send_beat = 1'b0;
    if (kind_e'(item_i.kind) == KindTick) begin
      since_d   = sat_inc(since_q);
      silence_d = sat_inc(silence_q);
      if (silence_d >= win) begin
        role_d    = toggle_role(role_q);
        silence_d = '0;
      end
      beat_d = sat_inc(beat_q);
      if (beat_d >= per) begin
        beat_d    = '0;
        send_beat = (role_d != RoleSecondary);
      end
    end else begin
      silence_d = '0;
      if (item_i.byte_count >= MinTaggedBytes) begin
        if (tag_hit) begin
          if (!from_self) begin
            role_d = RoleSecondary;
          end else if (role_q == RoleRaise) begin
            role_d = RolePrimary;
          end
          since_d = '0;
        end
      end else if (since_q >= cfg_i.stale_limit_ms) begin
        role_d = toggle_role(role_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q    <= RoleSecondary;
      since_q   <= '0;
      silence_q <= '0;
      beat_q    <= '0;
    end else if (en_i) begin
      role_q    <= role_d;
      since_q   <= since_d;
      silence_q <= silence_d;
      beat_q    <= beat_d;
    end
  end

  assign result_o.role         = role_d;
  assign result_o.send_beat    = send_beat;
  assign result_o.role_changed = (role_d != role_q);

`ifndef NO_ASSERTIONS
  a_packet_clears_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.kind == KindPacket) |=> silence_q == '0)
    else $error("packet did not restart the silence counter");

  a_tagged_clears_since: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.kind == KindPacket) && tag_hit |=> since_q == '0)
    else $error("tagged packet did not restart the staleness counter");

  a_no_beat_on_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.kind == KindPacket) |-> !result_o.send_beat)
    else $error("heartbeat requested on a packet word");

  a_idle_holds_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(role_q) && $stable(beat_q))
    else $error("state moved without a word");
`endif

endmodule

// ===== hw/rtl/heartbeat_role_election_top.sv =====
// Top level of the heartbeat role election block: input and result registers.
//
//   channel   direction  handshake                  payload
//   in        to block   in_valid_i / in_ready_o    in_word_i  (in_word_t)
//   out       from block out_valid_o / out_ready_i  out_word_o (out_word_t)
//   config    to block   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word per cycle while the result side is not stalled; a result is offered
// once its word has passed the input register and then the result register.
// The role update is one pass of logic between the two registers.
// Reset clears the role to secondary and all three counters to zero.
// A stalled result holds in the result register; the input register keeps
// taking words until it too is full, then in_ready_o drops.
module heartbeat_role_election_top import hre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  in_word_t  in_q;
  logic      in_valid_q;
  out_word_t out_q;
  logic      out_valid_q;
  out_word_t result;
  cfg_t      cfg;
  logic      advance;

  // Move the held word on whenever the result register is free or draining.
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  hre_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hre_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register: hold until the core takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== bench/hre_checker.sv =====
// Checker for the heartbeat role election block: predicts every result word and compares it.
module hre_checker import hre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_word_t          in_word_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_word_t         out_word_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [PdataW-1:0] pwdata_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  cfg_t            cfg_q;
  role_e           role_q;
  logic [CntW-1:0] since_tagged_q;
  logic [CntW-1:0] silence_q;
  logic [CntW-1:0] beat_q;
  out_word_t       role_results_q[$];
  int unsigned     fail_cnt;

  function automatic logic [CntW-1:0] count_up(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic role_e flip_role(input role_e r);
    return (r == RoleSecondary) ? RoleRaise : RoleSecondary;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_cnt++;
    $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  // Advance the election state by one word and return the result word it gives.
  task automatic elect(input in_word_t w, output out_word_t r);
    role_e           prior;
    logic [CntW-1:0] win;
    logic [CntW-1:0] per;
    logic            beat;
    prior = role_q;
    beat  = 1'b0;
    win   = (cfg_q.receive_window_ms == '0) ? CntW'(1) : cfg_q.receive_window_ms;
    per   = (cfg_q.beat_period_ms == '0) ? CntW'(1) : cfg_q.beat_period_ms;
    if (w.kind == KindTick) begin
      since_tagged_q = count_up(since_tagged_q);
      silence_q      = count_up(silence_q);
      if (silence_q >= win) begin
        role_q    = flip_role(role_q);
        silence_q = '0;
      end
      beat_q = count_up(beat_q);
      if (beat_q >= per) begin
        beat_q = '0;
        beat   = (role_q == RolePrimary) || (role_q == RoleRaise);
      end
    end else begin
      silence_q = '0;
      if (w.byte_count >= MinTaggedBytes) begin
        if (w.packet_tag == cfg_q.tag_value) begin
          if (w.sender_id == cfg_q.own_node_id &&
              w.sender_instance == cfg_q.own_instance) begin
            if (role_q == RoleRaise) role_q = RolePrimary;
          end else begin
            role_q = RoleSecondary;
          end
          since_tagged_q = '0;
        end
      end else if (since_tagged_q >= cfg_q.stale_limit_ms) begin
        role_q = flip_role(role_q);
      end
    end
    r.role         = role_q;
    r.send_beat    = beat;
    r.role_changed = (role_q != prior);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    out_word_t predicted;
    if (!rst_ni) begin
      cfg_q.tag_value         = TagValueRst;
      cfg_q.own_node_id       = '0;
      cfg_q.own_instance      = '0;
      cfg_q.stale_limit_ms    = StaleLimitRst;
      cfg_q.receive_window_ms = RxWindowRst;
      cfg_q.beat_period_ms    = BeatPeriodRst;
      role_q         = RoleSecondary;
      since_tagged_q = '0;
      silence_q      = '0;
      beat_q         = '0;
      fail_cnt       = 0;
      role_results_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PaddrW-1:2]))
          RegTagValue:   cfg_q.tag_value         = pwdata_i;
          RegOwnNodeId:  cfg_q.own_node_id       = pwdata_i[15:0];
          RegOwnInst:    cfg_q.own_instance      = pwdata_i[15:0];
          RegStaleLimit: cfg_q.stale_limit_ms    = pwdata_i[CntW-1:0];
          RegRxWindow:   cfg_q.receive_window_ms = pwdata_i[CntW-1:0];
          RegBeatPeriod: cfg_q.beat_period_ms    = pwdata_i[CntW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (role_results_q.size() == 0) begin
          report_mismatch("unpredicted result word, role", out_word_i.role, 0);
        end else begin
          want = role_results_q.pop_front();
          if (out_word_i.role !== want.role)
            report_mismatch("role", out_word_i.role, want.role);
          if (out_word_i.send_beat !== want.send_beat)
            report_mismatch("send_beat", out_word_i.send_beat, want.send_beat);
          if (out_word_i.role_changed !== want.role_changed)
            report_mismatch("role_changed", out_word_i.role_changed, want.role_changed);
        end
      end
      if (in_valid_i && in_ready_i) begin
        elect(in_word_i, predicted);
        role_results_q.push_back(predicted);
      end
      pending_o    <= role_results_q.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

// ===== bench/heartbeat_role_election_top_test.sv =====
// Testbench top for the heartbeat role election block: stimulus, watchdog and verdict.
module heartbeat_role_election_top_test;
  import hre_pkg::*;

  // Longest run of cycles with no word moving on any port before the run is called hung.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned WordsPerPhase = 200;
  localparam int unsigned ZeroWords     = 60;
  // Short run of ticks under full-scale limits: no window or beat may fire.
  localparam int unsigned FullScaleTicks = 40;
  // Idle cycles to wait after the last result is back, before reconfiguring.
  localparam int unsigned SettleCycles  = 4;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned idle_run;
  int unsigned stall_left;
  int unsigned tick_pct;
  logic        calm;

  // Setting currently loaded, so that heartbeats can be built to match it.
  logic [31:0]        cur_tag;
  logic signed [15:0] cur_id;
  logic signed [15:0] cur_inst;

  heartbeat_role_election_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  hre_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Gap length for either side: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: stall at random; no new stall starts while the bench is running calm.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 35) stall_left <= pick_gap();
    end
  end

  // Watchdog: any word on either channel or a register access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // A tick uses only its kind; fill the rest with noise so that it is seen to be ignored.
  function automatic in_word_t tick_word();
    in_word_t w;
    w.kind            = KindTick;
    w.byte_count      = 11'($urandom_range(0, 2047));
    w.packet_tag      = $urandom;
    w.sender_id       = 16'($urandom);
    w.sender_instance = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t packet_word(input int unsigned bytes, input logic [31:0] tag,
                                           input logic [15:0] id, input logic [15:0] inst);
    in_word_t w;
    w.kind            = KindPacket;
    w.byte_count      = 11'(bytes);
    w.packet_tag      = tag;
    w.sender_id       = id;
    w.sender_instance = inst;
    return w;
  endfunction

  // Length of a full-size packet, now and then beyond the nominal maximum.
  function automatic int unsigned long_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1025, 2047);
    return $urandom_range(8, 1024);
  endfunction

  // Random word: mostly ticks and well-formed heartbeats, the rest near misses and noise.
  function automatic in_word_t random_word();
    int unsigned        r;
    logic signed [15:0] other_id;
    logic signed [15:0] other_inst;
    r = $urandom_range(0, 99);
    if (r < tick_pct) return tick_word();
    r = $urandom_range(0, 99);
    if (r < 38) return packet_word(long_len(), cur_tag, cur_id, cur_inst);
    if (r < 58) begin
      other_id   = cur_id;
      other_inst = cur_inst;
      case ($urandom_range(0, 2))
        0: other_id = cur_id ^ 16'(1 << $urandom_range(0, 15));
        1: other_inst = cur_inst ^ 16'(1 << $urandom_range(0, 15));
        default: begin
          other_id   = 16'($urandom);
          other_inst = 16'($urandom);
        end
      endcase
      return packet_word(long_len(), cur_tag, other_id, other_inst);
    end
    if (r < 76) begin
      return packet_word($urandom_range(0, 7), ($urandom_range(0, 1) != 0) ? cur_tag : $urandom,
                         cur_id, cur_inst);
    end
    if (r < 88) begin
      return packet_word(long_len(), cur_tag ^ (32'd1 << $urandom_range(0, 31)),
                         cur_id, cur_inst);
    end
    return packet_word($urandom_range(0, 2047), $urandom, 16'($urandom), 16'($urandom));
  endfunction

  function automatic logic [31:0] pick_tag();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return TagValueRst;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Limits: mostly small so that windows and beats fire often, with the extremes mixed in.
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(25, 65534));
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // Offer one word after a random gap; hold it until taken.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One register write: setup phase, access phase, then psel dropped while idle.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] tag, input logic [15:0] id,
                           input logic [15:0] inst, input logic [15:0] stale,
                           input logic [15:0] window, input logic [15:0] period);
    cfg_write(RegTagValue, tag);
    cfg_write(RegOwnNodeId, {16'h0000, id});
    cfg_write(RegOwnInst, {16'h0000, inst});
    cfg_write(RegStaleLimit, {16'h0000, stale});
    cfg_write(RegRxWindow, {16'h0000, window});
    cfg_write(RegBeatPeriod, {16'h0000, period});
    cur_tag  = tag;
    cur_id   = id;
    cur_inst = inst;
  endtask

  initial begin
    // Hold every input at a known value from time zero.
    rst_n      = 1'b0;
    calm       = 1'b0;
    stall_left = 0;
    idle_run   = 0;
    tick_pct   = 55;
    cur_tag    = TagValueRst;
    cur_id     = '0;
    cur_inst   = '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    out_ready <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: own heartbeat while secondary, a fresh short packet, one tick.
    send_word(packet_word(8, TagValueRst, 16'h0000, 16'h0000));
    send_word(packet_word(0, 32'h0000_0000, 16'h0000, 16'h0000));
    send_word(tick_word());
    settle();

    // Tight limits and extreme identities, then walk through every transition.
    configure(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'd2, 16'd3, 16'd2);
    send_word(packet_word(8, cur_tag, cur_id, cur_inst));       // own beat, stays secondary
    repeat (3) send_word(tick_word());                          // window passes: raise hand
    send_word(packet_word(1024, cur_tag, cur_id, cur_inst));    // own beat: promote
    send_word(packet_word(2047, cur_tag, 16'h7FFF, cur_inst));  // other node: demote
    send_word(packet_word(7, cur_tag, cur_id, cur_inst));       // short but fresh
    repeat (2) send_word(tick_word());
    send_word(packet_word(0, 32'h0000_0000, 16'h0000, 16'h0000)); // short while stale
    send_word(packet_word(7, cur_tag, cur_id, cur_inst));       // stale again: back down
    send_word(packet_word(8, 32'hFFFF_FFFE, cur_id, cur_inst)); // wrong tag: silence only
    send_word(packet_word(1025, cur_tag, cur_id, 16'h0000));    // same id, other instance
    repeat (3) send_word(tick_word());
    send_word(packet_word(8, cur_tag, cur_id, cur_inst));       // promote again
    repeat (4) send_word(tick_word());                          // a beat while primary, then the window demotes
    settle();

    // Full-scale limits: a short run of ticks without idling, then a short packet.
    configure(cur_tag, cur_id, cur_inst, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    calm = 1'b1;
    repeat (FullScaleTicks) send_word(tick_word());
    send_word(packet_word(3, 32'h0000_0000, 16'h0000, 16'h0000));
    calm = 1'b0;
    settle();

    // Zero limits: every short packet is stale, window and beat fire on every tick.
    configure(32'h0000_0000, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0);
    repeat (ZeroWords) send_word(random_word());
    settle();

    // Random phases, each with its own setting, pace and mix of ticks.
    for (int p = 0; p < RandomPhases; p++) begin
      configure(pick_tag(), pick_id(), pick_id(), pick_limit(), pick_limit(), pick_limit());
      calm     = ($urandom_range(0, 3) == 0);
      tick_pct = $urandom_range(40, 85);
      repeat (WordsPerPhase) send_word(random_word());
      settle();
    end
    calm = 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
